// File: src/dmc_pkg.sv
// ----------------------------------------------------------------------------
// Differential Manchester codec package
// Shared types, operation codes and constants for the codec modules.
// ----------------------------------------------------------------------------
package dmc_pkg;

  // Operation codes carried in a request.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_ENC_BYTE  = 2'd0;
  localparam opcode_t OP_ENC_FRAME = 2'd1;
  localparam opcode_t OP_DEC_BYTE  = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_MID = 1'b1;

  // Cell and half-bit counts.
  localparam int CELLS_BYTE  = 8;
  localparam int CELLS_FRAME = 11;
  localparam int LINE_W      = 22;
  localparam logic [4:0] HALVES_BYTE  = 5'd16;
  localparam logic [4:0] HALVES_FRAME = 5'd22;
  localparam logic [4:0] HALVES_NONE  = 5'd0;

  // One request as held in the input register.
  typedef struct packed {
    opcode_t     opcode;
    logic [7:0]  data_byte;
    logic [15:0] half_bits;
  } req_t;

  // One result as held in the output register.
  typedef struct packed {
    logic [LINE_W-1:0] line_bits;
    logic [4:0]        half_bit_count;
    logic [7:0]        decoded_byte;
    logic              status;
  } rsp_t;

  localparam rsp_t RSP_ZERO = '{line_bits: '0, half_bit_count: HALVES_NONE,
                                decoded_byte: 8'd0, status: STATUS_OK};

endpackage

// File: src/dmc_req_if.sv
// ----------------------------------------------------------------------------
// Codec request channel
// Valid/ready channel that carries one codec request.
// ----------------------------------------------------------------------------
interface dmc_req_if;
  import dmc_pkg::*;

  logic        valid;
  logic        ready;
  opcode_t     opcode;
  logic [7:0]  data_byte;
  logic [15:0] half_bits;

  modport source (output valid, opcode, data_byte, half_bits, input ready);
  modport sink   (input valid, opcode, data_byte, half_bits, output ready);
endinterface

// File: src/dmc_rsp_if.sv
// ----------------------------------------------------------------------------
// Codec result channel
// Valid/ready channel that carries one codec result.
// ----------------------------------------------------------------------------
interface dmc_rsp_if;
  import dmc_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_bits;
  logic [4:0]        half_bit_count;
  logic [7:0]        decoded_byte;
  logic              status;

  modport source (output valid, line_bits, half_bit_count, decoded_byte, status,
                  input ready);
  modport sink   (input valid, line_bits, half_bit_count, decoded_byte, status,
                  output ready);
endinterface

// File: src/dmc_in_stage.sv
// ----------------------------------------------------------------------------
// Codec input register
// Takes a request whenever the register is empty or drains this cycle.
// ----------------------------------------------------------------------------
module dmc_in_stage (
  input  logic              clk,
  input  logic              rst,
  dmc_req_if.sink           req,
  input  logic              advance,
  output logic              valid,
  output dmc_pkg::req_t     item
);
  import dmc_pkg::*;

  // The register frees up in the same cycle that its content moves on.
  assign req.ready = !valid || advance;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Request payload.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.opcode    <= req.opcode;
      item.data_byte <= req.data_byte;
      item.half_bits <= req.half_bits;
    end
  end
endmodule

// File: src/dmc_encoder.sv
// ----------------------------------------------------------------------------
// Differential Manchester encoder
// Turns a byte, or a framed byte, into its half-bit line levels.
// ----------------------------------------------------------------------------
module dmc_encoder (
  input  logic              is_frame,
  input  logic [7:0]        data_byte,
  output dmc_pkg::rsp_t     result
);
  import dmc_pkg::*;

  logic                   parity;
  logic [CELLS_FRAME-1:0] frame_cells;
  logic [LINE_W-1:0]      byte_line;
  logic [LINE_W-1:0]      frame_line;
  logic                   lvl_b;
  logic                   lvl_f;
  logic                   first_b;
  logic                   first_f;

  // Frame cells, first sent at the top: start 0, data, even parity, stop 1.
  assign parity      = ^data_byte;
  assign frame_cells = {1'b0, data_byte, parity, 1'b1};

  // Line starts high; a 0 flips it at the cell start, every cell flips mid-cell.
  always_comb begin
    byte_line = '0;
    lvl_b     = 1'b1;
    first_b   = 1'b0;
    for (int k = 0; k < CELLS_BYTE; k++) begin
      first_b = data_byte[CELLS_BYTE-1-k] ? lvl_b : ~lvl_b;
      byte_line[2*CELLS_BYTE-1-2*k] = first_b;
      byte_line[2*CELLS_BYTE-2-2*k] = ~first_b;
      lvl_b = ~first_b;
    end
  end

  always_comb begin
    frame_line = '0;
    lvl_f      = 1'b1;
    first_f    = 1'b0;
    for (int k = 0; k < CELLS_FRAME; k++) begin
      first_f = frame_cells[CELLS_FRAME-1-k] ? lvl_f : ~lvl_f;
      frame_line[LINE_W-1-2*k] = first_f;
      frame_line[LINE_W-2-2*k] = ~first_f;
      lvl_f = ~first_f;
    end
  end

  // Select the result for the operation in hand.
  always_comb begin
    result = RSP_ZERO;
    if (is_frame) begin
      result.line_bits      = frame_line;
      result.half_bit_count = HALVES_FRAME;
    end else begin
      result.line_bits      = byte_line;
      result.half_bit_count = HALVES_BYTE;
    end
  end
endmodule

// File: src/dmc_decoder.sv
// ----------------------------------------------------------------------------
// Differential Manchester decoder
// Recovers a byte from sixteen half-bits and checks each mid-cell transition.
// ----------------------------------------------------------------------------
module dmc_decoder (
  input  logic [15:0]       half_bits,
  output dmc_pkg::rsp_t     result
);
  import dmc_pkg::*;

  logic [CELLS_BYTE-1:0] no_mid;
  logic [7:0]            bits;
  logic [CELLS_BYTE:1]   prev_lvl;

  // Level before each cell: idle high, then the second half of the last cell.
  assign prev_lvl[CELLS_BYTE] = 1'b1;

  // Each cell is checked and decoded on its own.
  always_comb begin
    for (int i = 0; i < CELLS_BYTE; i++) begin
      no_mid[CELLS_BYTE-1-i] = half_bits[15-2*i] == half_bits[14-2*i];
      bits[CELLS_BYTE-1-i]   = half_bits[15-2*i] == prev_lvl[CELLS_BYTE-i];
    end
  end

  for (genvar i = 1; i < CELLS_BYTE; i++) begin : g_lvl
    assign prev_lvl[CELLS_BYTE-i] = half_bits[16-2*i];
  end

  // A missing transition anywhere voids the byte.
  always_comb begin
    result = RSP_ZERO;
    if (|no_mid) begin
      result.status = STATUS_NO_MID;
    end else begin
      result.decoded_byte = bits;
    end
  end
endmodule

// File: src/dmc_out_stage.sv
// ----------------------------------------------------------------------------
// Codec result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module dmc_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  dmc_pkg::rsp_t     result,
  output logic              advance,
  dmc_rsp_if.source         rsp
);
  import dmc_pkg::*;

  // Load when the register is empty or its result leaves this cycle.
  assign advance = in_valid && (!rsp.valid || rsp.ready);

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.line_bits      <= result.line_bits;
      rsp.half_bit_count <= result.half_bit_count;
      rsp.decoded_byte   <= result.decoded_byte;
      rsp.status         <= result.status;
    end
  end
endmodule

// File: src/differential_manchester_codec.sv
// ----------------------------------------------------------------------------
// Differential Manchester codec
// Encodes a byte or a framed byte, or decodes sixteen half-bits, per request.
// ----------------------------------------------------------------------------
// Usage:
//   req is a valid/ready channel carrying opcode, data_byte and half_bits.
//   rsp is a valid/ready channel carrying line_bits, half_bit_count,
//   decoded_byte and status. Every request gives exactly one result.
//   A request is taken into an input register; the encoder and decoder work
//   on it combinationally and write the result register. The result shows on
//   rsp once the result register has loaded it from the input register.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the single logic pass between the two registers.
//   Reset clears both valid flags; no request or result is held after it.
//   When the receiver stalls, the result register holds its result, the
//   input register still takes one more request, and req.ready then drops
//   until the result register drains.
// ----------------------------------------------------------------------------
module differential_manchester_codec (
  input  logic      clk,
  input  logic      rst,
  dmc_req_if.sink   req,
  dmc_rsp_if.source rsp
);
  import dmc_pkg::*;

  logic  item_valid;
  req_t  item;
  logic  advance;
  rsp_t  enc_result;
  rsp_t  dec_result;
  rsp_t  result;

  dmc_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (advance),
    .valid   (item_valid),
    .item    (item)
  );

  dmc_encoder u_encoder (
    .is_frame  (item.opcode == OP_ENC_FRAME),
    .data_byte (item.data_byte),
    .result    (enc_result)
  );

  dmc_decoder u_decoder (
    .half_bits (item.half_bits),
    .result    (dec_result)
  );

  // Pick the result for the request's operation; an unused code gives zeros.
  always_comb begin
    unique case (item.opcode)
      OP_ENC_BYTE, OP_ENC_FRAME: begin
        result = enc_result;
      end
      OP_DEC_BYTE: begin
        result = dec_result;
      end
      default: begin
        result = RSP_ZERO;
      end
    endcase
  end

  dmc_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .result   (result),
    .advance  (advance),
    .rsp      (rsp)
  );
endmodule
